/* sv/midi_channel_message_parser_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the MIDI channel message parser
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_ASSERT_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_ASSERT_SVH

// same-cycle implication
`define MCMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mcmp_pkg.sv */
// ---------------------------------------------------------------------------
// mcmp_pkg
// Types and constants shared by the MIDI channel message parser.
// ---------------------------------------------------------------------------
package mcmp_pkg;

  localparam logic [7:0] STATUS_MIN = 8'h80;
  localparam logic [7:0] SYSTEM_MIN = 8'hF0;

  typedef enum logic [2:0] {
    MSG_NOTE_OFF      = 3'd0,
    MSG_NOTE_ON       = 3'd1,
    MSG_POLY_PRESSURE = 3'd2,
    MSG_CONTROL       = 3'd3,
    MSG_PROGRAM       = 3'd4,
    MSG_CHAN_PRESSURE = 3'd5,
    MSG_PITCH_BEND    = 3'd6
  } msg_type_t;

  typedef struct packed {
    msg_type_t   msg_type;
    logic [3:0]  msg_channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
  } msg_t;

  // number of data bytes that follow the status byte
  function automatic logic [1:0] data_bytes_needed(input msg_type_t t);
    logic [1:0] n;
    case (t)
      MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_PRESSURE,
      MSG_CONTROL, MSG_PITCH_BEND:        n = 2'd2;
      MSG_PROGRAM, MSG_CHAN_PRESSURE:     n = 2'd1;
      default:                            n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

/* sv/mcmp_if.sv */
// ---------------------------------------------------------------------------
// mcmp_byte_if / mcmp_msg_if
// Valid/ready channels for received bytes and parsed messages.
// ---------------------------------------------------------------------------
interface mcmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcmp_msg_if;
  logic                valid;
  logic                ready;
  mcmp_pkg::msg_type_t msg_type;
  logic [3:0]          msg_channel;
  logic [7:0]          data_first;
  logic [7:0]          data_second;

  modport source (output valid, output msg_type, output msg_channel,
                  output data_first, output data_second, input ready);
  modport sink   (input valid, input msg_type, input msg_channel,
                  input data_first, input data_second, output ready);
endinterface

/* sv/midi_channel_message_parser.sv */
// ---------------------------------------------------------------------------
// midi_channel_message_parser
// Parses MIDI channel-voice messages from a byte stream, one byte a cycle while in_ch.ready is high.
// ---------------------------------------------------------------------------
// Takes one byte per cycle whenever in_ch.ready is high, which it is unless
// both the output register and the skid entry hold messages. A message
// appears on out_ch in the cycle after the word carrying its last data byte is
// accepted when the output register is free or being drained in that cycle,
// and later when it has to wait behind a stalled message. The decode is a
// single pass between the parser state registers and the output register,
// so the sustained rate is one byte per cycle while out_ch keeps taking messages.
// Bytes below 0x80 and system bytes (0xF0 and up) are dropped while waiting
// for a status byte; there is no running status, and any byte that arrives
// while data is being collected counts as data.

module midi_channel_message_parser (
  input  logic              clk,
  input  logic              rst_n,
  mcmp_byte_if.sink         in_ch,
  mcmp_msg_if.source        out_ch
);

  logic                awaiting_r, awaiting_nxt;
  logic                held_r, held_nxt;       // first data byte held
  mcmp_pkg::msg_type_t pend_type_r, pend_type_nxt;
  logic [3:0]          pend_chan_r, pend_chan_nxt;
  logic [7:0]          held_data_r, held_data_nxt;

  logic                out_valid_r, out_valid_nxt;
  mcmp_pkg::msg_t      out_msg_r, out_msg_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  mcmp_pkg::msg_t      skid_msg_r, skid_msg_nxt;

  logic                in_fire, out_fire;
  logic                res_valid;
  mcmp_pkg::msg_t      res_msg;
  logic [7:0]          b;
  logic                out_one_byte;

  assign b        = in_ch.rx_byte;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  // parser
  always_comb begin
    awaiting_nxt  = awaiting_r;
    held_nxt      = held_r;
    pend_type_nxt = pend_type_r;
    pend_chan_nxt = pend_chan_r;
    held_data_nxt = held_data_r;
    res_valid     = 1'b0;
    res_msg.msg_type    = pend_type_r;
    res_msg.msg_channel = pend_chan_r;
    res_msg.data_first  = held_data_r;
    res_msg.data_second = b;
    if (in_fire) begin
      if (awaiting_r) begin
        if (b inside {[mcmp_pkg::STATUS_MIN : mcmp_pkg::SYSTEM_MIN - 8'd1]}) begin
          pend_type_nxt = mcmp_pkg::msg_type_t'(b[6:4]);
          pend_chan_nxt = b[3:0];
          held_nxt      = 1'b0;
          awaiting_nxt  = 1'b0;
        end
      end else if (!held_r) begin
        if (mcmp_pkg::data_bytes_needed(pend_type_r) == 2'd1) begin
          res_valid           = 1'b1;
          res_msg.data_first  = b;
          res_msg.data_second = 8'd0;
          awaiting_nxt        = 1'b1;
        end else begin
          held_data_nxt = b;
          held_nxt      = 1'b1;
        end
      end else begin
        res_valid    = 1'b1;
        awaiting_nxt = 1'b1;
        held_nxt     = 1'b0;
      end
    end
  end

  // output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_msg_nxt    = out_msg_r;
    skid_valid_nxt = skid_valid_r;
    skid_msg_nxt   = skid_msg_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_msg_nxt    = skid_msg_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_nxt = res_valid;
      out_msg_nxt   = res_msg;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_msg_nxt   = res_msg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r   <= 1'b1;
      held_r       <= 1'b0;
      pend_type_r  <= mcmp_pkg::MSG_NOTE_OFF;
      pend_chan_r  <= 4'd0;
      held_data_r  <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      awaiting_r   <= awaiting_nxt;
      held_r       <= held_nxt;
      pend_type_r  <= pend_type_nxt;
      pend_chan_r  <= pend_chan_nxt;
      held_data_r  <= held_data_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_msg_r  <= out_msg_nxt;
    skid_msg_r <= skid_msg_nxt;
  end

  assign in_ch.ready        = !skid_valid_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.msg_type    = out_msg_r.msg_type;
  assign out_ch.msg_channel = out_msg_r.msg_channel;
  assign out_ch.data_first  = out_msg_r.data_first;
  assign out_ch.data_second = out_msg_r.data_second;

  assign out_one_byte = (out_msg_r.msg_type == mcmp_pkg::MSG_PROGRAM) ||
                        (out_msg_r.msg_type == mcmp_pkg::MSG_CHAN_PRESSURE);

`include "midi_channel_message_parser_assert.svh"

  `MCMP_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `MCMP_ASSERT_NOW(a_no_type7, out_valid_r, out_msg_r.msg_type != 3'd7, "invalid message type")
  `MCMP_ASSERT_NOW(a_short_zero, out_valid_r && out_one_byte,
                   out_msg_r.data_second == 8'd0, "one-byte message with second data byte")
  `MCMP_ASSERT_NEXT(a_second_ends, in_fire && !awaiting_r && held_r,
                    awaiting_r && !held_r, "parser not waiting after second data word")
  `MCMP_ASSERT_NOW(a_held_not_waiting, held_r, !awaiting_r, "data held while waiting for status")

endmodule
